FILE: sv/qvr_pkg.sv
// Package with the widths and constants of the quaternion vector rotation pipeline.
`timescale 1ns / 1ps

package qvr_pkg;

  // Fixed field widths.
  localparam int QUAT_W = 16;
  localparam int VEC_IN_W = 16;
  localparam int OUT_W = 18;

  // Format of the quaternion and of the vector samples.
  localparam int QUAT_FRAC_BITS = 14;
  localparam int VEC_WIDTH = 16;

  // Only the low VEC_WIDTH bits of a sample are used; wider settings zero-extend the field.
  localparam int VEC_USE_W = (VEC_WIDTH < VEC_IN_W) ? VEC_WIDTH : VEC_IN_W;

  localparam int PROD_W = 2 * QUAT_W;
  localparam int FRAC_SHIFT = 2 * QUAT_FRAC_BITS;
  // A matrix entry is 2^FRAC_SHIFT minus twice a sum of two squares, or twice a sum or difference
  // of two products, so two bits above the larger of the two magnitudes suffice.
  localparam int COEF_W = ((FRAC_SHIFT > PROD_W) ? FRAC_SHIFT : PROD_W) + 2;
  localparam int MUL_W = COEF_W + VEC_WIDTH;
  // Three products plus the rounding half.
  localparam int SUM_W = MUL_W + 3;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [PROD_W-1:0] wx;
    logic signed [PROD_W-1:0] wy;
    logic signed [PROD_W-1:0] wz;
    logic signed [PROD_W-1:0] xx;
    logic signed [PROD_W-1:0] xy;
    logic signed [PROD_W-1:0] xz;
    logic signed [PROD_W-1:0] yy;
    logic signed [PROD_W-1:0] yz;
    logic signed [PROD_W-1:0] zz;
  } prod_t;

endpackage

FILE: sv/quaternion_vector_rotation.sv
// Top level of the quaternion vector rotation pipeline.
`timescale 1ns / 1ps

// Rotates one vector by a quaternion per clock. An item is taken whenever start_i is high;
// busy_o is always low because the five-stage pipeline (quaternion products, matrix entries,
// matrix-vector products, row sums, rounding and saturation) advances every cycle. The result
// appears on the rot ports from the rounding and saturation register, marked by done_o for one
// cycle, and must be taken then. The quaternion is used as given, without normalisation;
// clipped_o is set if any component had to be saturated to 18 bits.
module quaternion_vector_rotation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_w_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_x_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_y_i,
  input  logic signed [qvr_pkg::QUAT_W-1:0]    quat_z_i,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0]  vec_x_i,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0]  vec_y_i,
  input  logic signed [qvr_pkg::VEC_IN_W-1:0]  vec_z_i,
  output logic                                 done_o,
  output logic signed [qvr_pkg::OUT_W-1:0]     rot_x_o,
  output logic signed [qvr_pkg::OUT_W-1:0]     rot_y_o,
  output logic signed [qvr_pkg::OUT_W-1:0]     rot_z_o,
  output logic                                 clipped_o
);
  import qvr_pkg::*;

  localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(1) << FRAC_SHIFT;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

  logic [3:0] vld_q;
  logic       done_q;

  prod_t prod_d, prod_q;
  logic signed [VEC_WIDTH-1:0] vec_d [3];
  logic signed [VEC_WIDTH-1:0] vec1_q [3];
  logic signed [VEC_WIDTH-1:0] vec2_q [3];
  logic signed [COEF_W-1:0]    coef_d [3][3];
  logic signed [COEF_W-1:0]    coef_q [3][3];
  logic signed [MUL_W-1:0]     mul_d [3][3];
  logic signed [MUL_W-1:0]     mul_q [3][3];
  logic signed [SUM_W-1:0]     sum_d [3];
  logic signed [SUM_W-1:0]     sum_q [3];
  logic signed [OUT_W-1:0]     rot_d [3];
  logic signed [OUT_W-1:0]     rot_q [3];
  logic                        clip_d, clip_q;

  assign busy_o = 1'b0;

  // Stage one: the nine pairwise quaternion products and the samples in their working width.
  always_comb begin
    logic [VEC_WIDTH-1:0] raw_x, raw_y, raw_z;
    raw_x = VEC_WIDTH'(vec_x_i[VEC_USE_W-1:0]);
    raw_y = VEC_WIDTH'(vec_y_i[VEC_USE_W-1:0]);
    raw_z = VEC_WIDTH'(vec_z_i[VEC_USE_W-1:0]);
    vec_d[0] = signed'(raw_x);
    vec_d[1] = signed'(raw_y);
    vec_d[2] = signed'(raw_z);
    prod_d.wx = PROD_W'(quat_w_i) * PROD_W'(quat_x_i);
    prod_d.wy = PROD_W'(quat_w_i) * PROD_W'(quat_y_i);
    prod_d.wz = PROD_W'(quat_w_i) * PROD_W'(quat_z_i);
    prod_d.xx = PROD_W'(quat_x_i) * PROD_W'(quat_x_i);
    prod_d.xy = PROD_W'(quat_x_i) * PROD_W'(quat_y_i);
    prod_d.xz = PROD_W'(quat_x_i) * PROD_W'(quat_z_i);
    prod_d.yy = PROD_W'(quat_y_i) * PROD_W'(quat_y_i);
    prod_d.yz = PROD_W'(quat_y_i) * PROD_W'(quat_z_i);
    prod_d.zz = PROD_W'(quat_z_i) * PROD_W'(quat_z_i);
  end

  // Stage two: the rotation matrix, exact in the doubled fraction format.
  always_comb begin
    logic signed [COEF_W-1:0] s_yz2, s_xz2, s_xy2;
    s_yz2 = COEF_W'(prod_q.yy) + COEF_W'(prod_q.zz);
    s_xz2 = COEF_W'(prod_q.xx) + COEF_W'(prod_q.zz);
    s_xy2 = COEF_W'(prod_q.xx) + COEF_W'(prod_q.yy);
    coef_d[0][0] = COEF_ONE - (s_yz2 <<< 1);
    coef_d[0][1] = (COEF_W'(prod_q.xy) - COEF_W'(prod_q.wz)) <<< 1;
    coef_d[0][2] = (COEF_W'(prod_q.xz) + COEF_W'(prod_q.wy)) <<< 1;
    coef_d[1][0] = (COEF_W'(prod_q.xy) + COEF_W'(prod_q.wz)) <<< 1;
    coef_d[1][1] = COEF_ONE - (s_xz2 <<< 1);
    coef_d[1][2] = (COEF_W'(prod_q.yz) - COEF_W'(prod_q.wx)) <<< 1;
    coef_d[2][0] = (COEF_W'(prod_q.xz) - COEF_W'(prod_q.wy)) <<< 1;
    coef_d[2][1] = (COEF_W'(prod_q.yz) + COEF_W'(prod_q.wx)) <<< 1;
    coef_d[2][2] = COEF_ONE - (s_xy2 <<< 1);
  end

  // Stage three: one multiplier for each matrix entry.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mul_d[r][c] = MUL_W'(coef_q[r][c]) * MUL_W'(vec2_q[c]);
      end
    end
  end

  // Stage four: exact row sums with the rounding half already added.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_d[r] = SUM_W'(mul_q[r][0]) + SUM_W'(mul_q[r][1]) + SUM_W'(mul_q[r][2])
                 + ROUND_HALF;
    end
  end

  // Stage five: drop the fraction (floor after adding half) and saturate.
  always_comb begin
    logic signed [SUM_W-1:0] shifted;
    shifted = '0;
    clip_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      shifted = sum_q[r] >>> FRAC_SHIFT;
      if (shifted > SAT_HI) begin
        rot_d[r] = OUT_MAX;
        clip_d = 1'b1;
      end else if (shifted < SAT_LO) begin
        rot_d[r] = OUT_MIN;
        clip_d = 1'b1;
      end else begin
        rot_d[r] = shifted[OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[2:0], start_i & ~busy_o};
      done_q <= vld_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      prod_q <= prod_d;
      vec1_q <= vec_d;
    end
    if (vld_q[0]) begin
      coef_q <= coef_d;
      vec2_q <= vec1_q;
    end
    if (vld_q[1]) begin
      mul_q <= mul_d;
    end
    if (vld_q[2]) begin
      sum_q <= sum_d;
    end
    if (vld_q[3]) begin
      rot_q  <= rot_d;
      clip_q <= clip_d;
    end
  end

  assign done_o    = done_q;
  assign rot_x_o   = rot_q[0];
  assign rot_y_o   = rot_q[1];
  assign rot_z_o   = rot_q[2];
  assign clipped_o = clip_q;

`ifndef SYNTH
  // Every transfer yields a result on done_o.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##5 done_o)
    else $error("transfer did not produce a result after five cycles");

  // No result appears without a matching earlier transfer.
  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 5))
    else $error("result without a matching transfer");

  // A saturated result has at least one component on a rail.
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |->
      (rot_x_o == OUT_MAX || rot_x_o == OUT_MIN ||
       rot_y_o == OUT_MAX || rot_y_o == OUT_MIN ||
       rot_z_o == OUT_MAX || rot_z_o == OUT_MIN))
    else $error("clipped set but no component saturated");
`endif

endmodule
